[hdl/pmed_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmed_pkg - shared types and constants
// Constants, queue status type and helpers for the PIR motion energy detector.
// ----------------------------------------------------------------------------
package pmed_pkg;

	localparam int WINDOW_LEN_DEF = 15;
	localparam int SAMPLE_W       = 16;
	localparam int CENTER_W       = 8;
	localparam int ENERGY_W       = 11;
	localparam int THRESH_W       = 11;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd80;
	localparam logic [ENERGY_W-1:0] ENERGY_MAX   = 11'd2047;

	// x / 5 == (x * DIV5_RECIP) >> DIV5_SHIFT for every x below 2^19
	localparam int WSUM_W     = SAMPLE_W + 3;
	localparam int DIV5_SHIFT = 21;
	localparam logic [WSUM_W-1:0] DIV5_RECIP = 19'd419431;

	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// magnitude of a two's complement byte, -128 gives 128
	function automatic logic [CENTER_W-1:0] mag8(input logic [CENTER_W-1:0] v);
		logic [CENTER_W-1:0] m;
		m = v[CENTER_W-1] ? (~v + 8'd1) : v;
		return m;
	endfunction

endpackage
`default_nettype wire

[hdl/pir_motion_energy_detector_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pir_motion_energy_detector_core - PIR motion energy detector
// DC offset removal, sliding window of centered bytes and energy threshold.
// ----------------------------------------------------------------------------
// An accepted sample's centered byte is queued, then popped into the output register.
// Throughput: one sample per cycle when not stalled; the offset update (multiply by
//   the reciprocal of five) is combinational; the window sum is kept as a running total.
// The two-entry queue between front and back lets either side stall alone.
// Reset clears the offset (not loaded), the window, the queue and out_valid, and sets
//   the motion threshold to 80; output data is not reset. No clearing pass is needed.
module pir_motion_energy_detector_core #(
	parameter int WINDOW_LEN = pmed_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [pmed_pkg::SAMPLE_W-1:0]     sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   motion,
	output logic      [pmed_pkg::ENERGY_W-1:0]     energy,
	output logic signed [pmed_pkg::CENTER_W-1:0]   centered,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pmed_pkg::THRESH_W-1:0]     cfg_data
);

	logic                          take;
	logic [pmed_pkg::CENTER_W-1:0] front_val;
	logic                          pop;
	logic [pmed_pkg::CENTER_W-1:0] pop_data;
	pmed_pkg::fifo_stat_t          stat;
	logic [pmed_pkg::THRESH_W-1:0] thresh_q;

	assign in_stall  = stat.full;
	assign take      = in_valid && !stat.full;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= pmed_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	pmed_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.sample       (sample),
		.centered_val (front_val)
	);

	pmed_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (front_val),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	pmed_back #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.threshold (thresh_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.motion    (motion),
		.energy    (energy),
		.centered  (centered)
	);

endmodule
`default_nettype wire

[hdl/pmed_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmed_front - offset tracker
// Accepts samples, updates the DC offset and produces the centered byte.
// ----------------------------------------------------------------------------
module pmed_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             take,
	input  wire logic [pmed_pkg::SAMPLE_W-1:0]    sample,
	output logic      [pmed_pkg::CENTER_W-1:0]    centered_val
);

	logic [pmed_pkg::SAMPLE_W-1:0]   offset_q;
	logic [pmed_pkg::SAMPLE_W-1:0]   offset_next;
	logic [pmed_pkg::WSUM_W-1:0]     wsum;
	logic [2*pmed_pkg::WSUM_W-1:0]   prod;
	logic [pmed_pkg::SAMPLE_W-1:0]   quot;

	// (4*offset + sample) / 5 through a reciprocal multiply
	assign wsum = {1'b0, offset_q, 2'b00} + pmed_pkg::WSUM_W'(sample);
	assign prod = (2*pmed_pkg::WSUM_W)'(wsum) * (2*pmed_pkg::WSUM_W)'(pmed_pkg::DIV5_RECIP);
	assign quot = prod[pmed_pkg::DIV5_SHIFT +: pmed_pkg::SAMPLE_W];

	// zero offset means not loaded yet
	assign offset_next  = (offset_q == '0) ? sample : quot;
	assign centered_val = sample[pmed_pkg::CENTER_W-1:0] -
		offset_next[pmed_pkg::CENTER_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (take) begin
			offset_q <= offset_next;
		end
	end

endmodule
`default_nettype wire

[hdl/pmed_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmed_fifo - decoupling queue
// Short queue of centered bytes between the front and back parts.
// ----------------------------------------------------------------------------
module pmed_fifo (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  wire logic [pmed_pkg::CENTER_W-1:0]    push_data,
	input  wire logic                             pop,
	output logic      [pmed_pkg::CENTER_W-1:0]    pop_data,
	output pmed_pkg::fifo_stat_t                  stat
);

	localparam int DEPTH = pmed_pkg::FIFO_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [pmed_pkg::CENTER_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]              wr_ptr_q;
	logic [PTR_W-1:0]              rd_ptr_q;
	logic [CNT_W-1:0]              count_q;

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/pmed_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmed_back - window energy
// Shift-line window of centered bytes, running magnitude sum, output register.
// ----------------------------------------------------------------------------
module pmed_back #(
	parameter int WINDOW_LEN = pmed_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pmed_pkg::fifo_stat_t             stat,
	input  wire logic [pmed_pkg::CENTER_W-1:0]    pop_data,
	output logic                                  pop,
	input  wire logic [pmed_pkg::THRESH_W-1:0]    threshold,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  motion,
	output logic      [pmed_pkg::ENERGY_W-1:0]    energy,
	output logic signed [pmed_pkg::CENTER_W-1:0]  centered
);

	localparam int SUM_MAX = WINDOW_LEN * 128;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int EXT_W   = SUM_W + pmed_pkg::ENERGY_W;

	logic [pmed_pkg::CENTER_W-1:0] taps_q [WINDOW_LEN];
	logic [SUM_W-1:0]              sum_q;
	logic [SUM_W-1:0]              sum_next;
	logic [EXT_W-1:0]              sum_ext;
	logic [pmed_pkg::ENERGY_W-1:0] energy_next;
	logic                          out_valid_q;
	logic                          motion_q;
	logic [pmed_pkg::ENERGY_W-1:0] energy_q;
	logic [pmed_pkg::CENTER_W-1:0] centered_q;

	assign pop = !stat.empty && (!out_valid_q || !out_stall);

	// new beat enters, oldest tap leaves
	assign sum_next = sum_q
		- SUM_W'(pmed_pkg::mag8(taps_q[WINDOW_LEN-1]))
		+ SUM_W'(pmed_pkg::mag8(pop_data));
	assign sum_ext     = EXT_W'(sum_next);
	assign energy_next = (sum_ext > EXT_W'(pmed_pkg::ENERGY_MAX)) ?
		pmed_pkg::ENERGY_MAX : sum_ext[pmed_pkg::ENERGY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				taps_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (pop) begin
			taps_q[0] <= pop_data;
			for (int i = 1; i < WINDOW_LEN; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			motion_q   <= (energy_next >= threshold);
			energy_q   <= energy_next;
			centered_q <= pop_data;
		end
	end

	assign out_valid = out_valid_q;
	assign motion    = motion_q;
	assign energy    = energy_q;
	assign centered  = centered_q;

`ifndef SYNTH
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(SUM_MAX))
		else $error("window sum above its bound");

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped beat did not reach the output register");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(sum_q))
		else $error("window sum moved without a beat");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb - PIR motion energy detector testbench
// Drives converter samples through the core with random idling on both sides,
// tracks offset, window and energy in a local model and checks every result
// beat field by field. The motion threshold is changed between drained phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                                 motion;
		logic [pmed_pkg::ENERGY_W-1:0]        energy;
		logic signed [pmed_pkg::CENTER_W-1:0] centered;
	} reading_t;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AT     = 500;
	localparam int HOLD_LEN    = 120;
	localparam int PHASE_LEN   = 320;
	localparam logic [pmed_pkg::SAMPLE_W-1:0] OPENING [22] = '{
		16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 16'd0, 16'd5, 16'd6, 16'd4,
		16'd65534, 16'd65534, 16'd0, 16'd32768, 16'd32767, 16'd21845, 16'd43690,
		16'd1, 16'd2, 16'd255, 16'd256, 16'd128, 16'd127
	};

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [pmed_pkg::SAMPLE_W-1:0]        sample = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic                                 motion;
	logic [pmed_pkg::ENERGY_W-1:0]        energy;
	logic signed [pmed_pkg::CENTER_W-1:0] centered;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [pmed_pkg::THRESH_W-1:0]        cfg_data = '0;

	// local copy of the detector state
	logic [pmed_pkg::SAMPLE_W-1:0]        dc_est = '0;
	logic [pmed_pkg::CENTER_W-1:0]        ring [pmed_pkg::WINDOW_LEN_DEF];
	int                                   ring_slot = 0;
	logic [pmed_pkg::THRESH_W-1:0]        thresh = pmed_pkg::THRESH_RESET;

	logic [pmed_pkg::SAMPLE_W-1:0]        samples_q [$];
	reading_t                             readings_due [$];
	int                                   sample_held = 0;
	int                                   in_gap = 0;
	int                                   out_gap = 0;
	int                                   idle_pct = 0;
	int                                   out_beats = 0;
	int                                   hold_left = 0;
	bit                                   hold_done = 1'b0;
	int                                   fails = 0;
	int                                   quiet_cycles = 0;

	pir_motion_energy_detector_core #(
		.WINDOW_LEN(pmed_pkg::WINDOW_LEN_DEF)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.motion    (motion),
		.energy    (energy),
		.centered  (centered),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// offset update, window write and energy for one sample
	function automatic reading_t track_sample(input logic [pmed_pkg::SAMPLE_W-1:0] s);
		int unsigned                   avg;
		int unsigned                   sum;
		logic [pmed_pkg::SAMPLE_W-1:0] diff;
		logic [pmed_pkg::CENTER_W-1:0] c;
		reading_t                      r;
		if (dc_est == '0) begin
			dc_est = s;
		end else begin
			avg = ({16'd0, dc_est} * 32'd4 + {16'd0, s}) / 32'd5;
			dc_est = avg[pmed_pkg::SAMPLE_W-1:0];
		end
		diff = s - dc_est;
		c = diff[pmed_pkg::CENTER_W-1:0];
		ring[ring_slot] = c;
		ring_slot = (ring_slot + 1) % pmed_pkg::WINDOW_LEN_DEF;
		sum = 0;
		for (int i = 0; i < pmed_pkg::WINDOW_LEN_DEF; i++) begin
			if (ring[i][pmed_pkg::CENTER_W-1])
				sum += 32'd256 - {24'd0, ring[i]};
			else
				sum += {24'd0, ring[i]};
		end
		if (sum > pmed_pkg::ENERGY_MAX)
			sum = pmed_pkg::ENERGY_MAX;
		r.energy = sum[pmed_pkg::ENERGY_W-1:0];
		r.motion = (sum >= {21'd0, thresh});
		r.centered = c;
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				readings_due.push_back(track_sample(sample));
				sample_held = 0;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (samples_q.size() > 0 && idle_pct > 0 &&
						$urandom_range(0, 99) < idle_pct) begin
					in_gap = $urandom_range(1, 10) - 1;
					in_valid <= 1'b0;
				end else if (samples_q.size() > 0) begin
					sample <= samples_q.pop_front();
					sample_held = 1;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_beats++;
				if (readings_due.size() == 0) begin
					$error("result beat with nothing expected: motion %0d energy %0d centered %0d",
						motion, energy, centered);
					fails++;
				end else begin
					want = readings_due.pop_front();
					if (motion !== want.motion) begin
						$error("motion: expected %0d, got %0d", want.motion, motion);
						fails++;
					end
					if (energy !== want.energy) begin
						$error("energy: expected %0d, got %0d", want.energy, energy);
						fails++;
					end
					if (centered !== want.centered) begin
						$error("centered: expected %0d, got %0d", want.centered, centered);
						fails++;
					end
				end
			end
			// one long hold-off so the block backs up and stalls its input
			if (!hold_done && out_beats >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				out_gap = $urandom_range(1, 10) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic drain();
		while (samples_q.size() > 0 || sample_held != 0 || readings_due.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [pmed_pkg::THRESH_W-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thresh = v;
	endtask

	// scenes: steady baselines with small noise, motion bursts, rails and raw noise
	task automatic queue_scenes(input int n);
		int pushed;
		int r;
		int base;
		int amp;
		int len;
		int v;
		pushed = 0;
		while (pushed < n) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				base = $urandom_range(0, 65534);
				amp = $urandom_range(0, 4);
				len = $urandom_range(20, 60);
			end else if (r < 80) begin
				base = $urandom_range(0, 65534);
				amp = $urandom_range(10, 120);
				len = $urandom_range(15, 40);
			end else if (r < 90) begin
				// low rail lets the offset decay to zero and reload
				base = ($urandom_range(0, 1) != 0) ? 0 : 65534;
				amp = $urandom_range(0, 1);
				len = $urandom_range(60, 90);
			end else begin
				base = 0;
				amp = -1;
				len = $urandom_range(5, 20);
			end
			for (int i = 0; i < len && pushed < n; i++) begin
				if (amp < 0)
					v = $urandom_range(0, 65534);
				else
					v = base + $urandom_range(0, 2 * amp) - amp;
				if (v < 0)
					v = 0;
				if (v > 65534)
					v = 65534;
				samples_q.push_back(v[pmed_pkg::SAMPLE_W-1:0]);
				pushed++;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < pmed_pkg::WINDOW_LEN_DEF; i++)
			ring[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 20;
		foreach (OPENING[i])
			samples_q.push_back(OPENING[i]);
		drain();

		idle_pct = 25;
		queue_scenes(PHASE_LEN);
		drain();

		write_threshold('0);
		idle_pct = 40;
		queue_scenes(PHASE_LEN);
		drain();

		write_threshold(pmed_pkg::ENERGY_MAX);
		idle_pct = 10;
		queue_scenes(PHASE_LEN);
		drain();

		write_threshold($urandom_range(0, 2047));
		idle_pct = 30;
		queue_scenes(PHASE_LEN);
		drain();

		// last stretch runs at full rate on both sides
		write_threshold($urandom_range(20, 400));
		idle_pct = 0;
		queue_scenes(PHASE_LEN);
		drain();

		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[pir_motion_energy_detector_core.f]
hdl/pmed_pkg.sv
hdl/pmed_front.sv
hdl/pmed_fifo.sv
hdl/pmed_back.sv
hdl/pir_motion_energy_detector_core.sv
verif/tb.sv
